@@ design/probe_scheduler_with_credit_and_retry_top_macros.svh @@
// Assertion helpers used by the checker file of the probe scheduler.
`ifndef PROBE_SCHEDULER_WITH_CREDIT_AND_RETRY_TOP_MACROS_SVH
`define PROBE_SCHEDULER_WITH_CREDIT_AND_RETRY_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSCHED_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSCHED_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/psched_pkg.sv @@
`default_nettype none

package psched_pkg;

   // Depth of the port status table.
   localparam int PORT_SLOTS_DEFAULT = 65536;

   // Configuration port.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes (byte address divided by four).
   localparam logic [1:0] REG_FIRST_PORT   = 2'd0;
   localparam logic [1:0] REG_LAST_PORT    = 2'd1;
   localparam logic [1:0] REG_CREDIT_LIMIT = 2'd2;
   localparam logic [1:0] REG_PASS_LIMIT   = 2'd3;

   // Register reset values.
   localparam logic [15:0] FIRST_PORT_RESET   = 16'd1;
   localparam logic [15:0] LAST_PORT_RESET    = 16'd1024;
   localparam logic [9:0]  CREDIT_LIMIT_RESET = 10'd100;
   localparam logic [3:0]  PASS_LIMIT_RESET   = 4'd2;

   // The credit saturates at this value.
   localparam logic [9:0] CREDIT_MAX = 10'd1023;

   // Command codes.
   localparam logic [2:0] CMD_START    = 3'd0;
   localparam logic [2:0] CMD_SEND     = 3'd1;
   localparam logic [2:0] CMD_RESPONSE = 3'd2;
   localparam logic [2:0] CMD_TIMEOUT  = 3'd3;
   localparam logic [2:0] CMD_READ     = 3'd4;

   // Entry status codes.
   localparam logic [1:0] STATUS_FILTERED = 2'd0;
   localparam logic [1:0] STATUS_OPEN     = 2'd1;
   localparam logic [1:0] STATUS_CLOSED   = 2'd2;

   typedef struct packed {
      logic [2:0]  command;
      logic [15:0] port;
      logic        reply_kind;
      logic        link_busy;
      logic        link_error;
   } req_item_type;

   typedef struct packed {
      logic        probe_valid;
      logic [15:0] probe_port;
      logic        restart_timer;
      logic        send_enabled;
      logic        running;
      logic        aborted;
      logic        duplicate;
      logic [1:0]  entry_status;
   } rsp_item_type;

endpackage

`default_nettype wire

@@ design/probe_scheduler_with_credit_and_retry_top.sv @@
// Channel        Direction  Handshake                Payload
// command in     input      start / busy             req_item  (req_item_type)
// result out     output     rsp_valid strobe         rsp_item  (rsp_item_type)
// registers      both       psel / penable / pready  paddr, pwdata, prdata
//
// A command is taken at a rising edge with start high and busy low and gives one result,
// shown for one cycle with rsp_valid while busy is already low, so the next command may
// be taken then. A command that does not touch the table goes straight to S_REPORT; a
// response or read that reads it first passes its read and check states; a live send
// reads and checks entries, skipping answered ones; a start clears the range in S_CLEAR.
// Reset is synchronous and leaves the block idle; the receiver cannot stall.
`default_nettype none

module probe_scheduler_with_credit_and_retry_top #(
   parameter int PORT_SLOTS = psched_pkg::PORT_SLOTS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire psched_pkg::req_item_type              req_item,
   output logic                                       rsp_valid,
   output psched_pkg::rsp_item_type                   rsp_item,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [psched_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [psched_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [psched_pkg::CSR_DATA_W-1:0]          prdata,
   output logic                                       pready
);
   import psched_pkg::*;

   // Table index width and the width that can hold the range size itself.
   localparam int IDX_W  = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;
   localparam int SIZE_W = $clog2(PORT_SLOTS + 1);
   localparam logic [16:0] SLOTS17 = 17'(PORT_SLOTS);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_WALK_RD,
      S_WALK_CHK,
      S_RESP_RD,
      S_RESP_CHK,
      S_READ_RD,
      S_READ_CHK,
      S_REPORT
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [15:0] first_port_ff, first_port_in;
   logic [15:0] last_port_ff, last_port_in;
   logic [9:0]  credit_limit_ff, credit_limit_in;
   logic [3:0]  pass_limit_ff, pass_limit_in;

   // Scan state.
   logic [15:0]       base_ff, base_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [IDX_W-1:0]  cursor_ff, cursor_in;
   logic [3:0]        passes_ff, passes_in;
   logic [9:0]        credit_ff, credit_in;
   logic [SIZE_W-1:0] answered_ff, answered_in;
   logic              send_en_ff, send_en_in;
   logic              abort_ff, abort_in;
   logic              finished_ff, finished_in;

   // Per-command working registers.
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic             kind_ff, kind_in;
   logic             link_busy_ff, link_busy_in;
   logic             link_error_ff, link_error_in;
   logic             probe_valid_ff, probe_valid_in;
   logic [15:0]      probe_port_ff, probe_port_in;
   logic             dup_ff, dup_in;
   logic [1:0]       status_ff, status_in;

   // Result register.
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   // Status memory with one write port and one registered read port.
   logic [1:0]       status_mem [PORT_SLOTS];
   logic [1:0]       rd_data_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [1:0]       mem_wdata;
   logic [IDX_W-1:0] mem_raddr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         status_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= status_mem[mem_raddr];
   end

   // The scan is running while not finished, not aborted and not fully answered.
   logic run;
   assign run = !finished_ff && !abort_ff && (answered_ff < size_ff);

   // Shared cursor stepper: advance by one, wrap at the range end and use a pass.
   logic [SIZE_W-1:0] step_next;
   logic              step_wrap;
   logic [IDX_W-1:0]  step_cursor;
   logic [3:0]        step_passes;

   assign step_next   = SIZE_W'(cursor_ff) + SIZE_W'(1);
   assign step_wrap   = step_next >= size_ff;
   assign step_cursor = step_wrap ? '0 : step_next[IDX_W-1:0];
   assign step_passes = (step_wrap && passes_ff != 4'd0) ? passes_ff - 4'd1 : passes_ff;

   // Range of a new start, cut to the table depth.
   logic [16:0] size_raw;
   logic        range_bad;
   logic [16:0] size_new;

   assign size_raw  = {1'b0, last_port_ff} - {1'b0, first_port_ff} + 17'd1;
   assign range_bad = (first_port_ff == 16'd0) || (last_port_ff < first_port_ff);
   assign size_new  = range_bad ? 17'd0 : ((size_raw > SLOTS17) ? SLOTS17 : size_raw);

   // Table index of the port carried by a response or a read.
   logic [16:0] idx_full;
   logic        in_range;

   assign idx_full = {1'b0, req_item.port} - {1'b0, base_ff};
   assign in_range = (req_item.port >= base_ff) && (idx_full < 17'(size_ff));

   // The clearing pass stops on the last entry of the range.
   logic clr_last;
   assign clr_last = (SIZE_W'(addr_ff) + SIZE_W'(1)) >= size_ff;

   // Increments used when a new response is stored, and the credit decrement of a probe.
   logic [9:0]        credit_inc;
   logic [SIZE_W-1:0] answered_inc;
   logic [9:0]        credit_dec;

   assign credit_inc   = (credit_ff == CREDIT_MAX) ? credit_ff : credit_ff + 10'd1;
   assign answered_inc = answered_ff + SIZE_W'(1);
   assign credit_dec   = (credit_ff != 10'd0) ? credit_ff - 10'd1 : credit_ff;

   // Register writes complete on the access cycle; reads return the register value.
   logic csr_write;
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_comb begin
      first_port_in   = first_port_ff;
      last_port_in    = last_port_ff;
      credit_limit_in = credit_limit_ff;
      pass_limit_in   = pass_limit_ff;
      if (csr_write) begin
         unique case (paddr[3:2])
            REG_FIRST_PORT:   first_port_in   = pwdata[15:0];
            REG_LAST_PORT:    last_port_in    = pwdata[15:0];
            REG_CREDIT_LIMIT: credit_limit_in = pwdata[9:0];
            REG_PASS_LIMIT:   pass_limit_in   = pwdata[3:0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_FIRST_PORT:   prdata = {16'd0, first_port_ff};
         REG_LAST_PORT:    prdata = {16'd0, last_port_ff};
         REG_CREDIT_LIMIT: prdata = {22'd0, credit_limit_ff};
         REG_PASS_LIMIT:   prdata = {28'd0, pass_limit_ff};
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      base_in        = base_ff;
      size_in        = size_ff;
      cursor_in      = cursor_ff;
      passes_in      = passes_ff;
      credit_in      = credit_ff;
      answered_in    = answered_ff;
      send_en_in     = send_en_ff;
      abort_in       = abort_ff;
      finished_in    = finished_ff;
      addr_in        = addr_ff;
      kind_in        = kind_ff;
      link_busy_in   = link_busy_ff;
      link_error_in  = link_error_ff;
      probe_valid_in = probe_valid_ff;
      probe_port_in  = probe_port_ff;
      dup_in         = dup_ff;
      status_in      = status_ff;
      rsp_valid_in   = 1'b0;
      rsp_item_in    = rsp_item_ff;
      mem_we         = 1'b0;
      mem_waddr      = addr_ff;
      mem_wdata      = STATUS_FILTERED;
      mem_raddr      = addr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in        = req_item.reply_kind;
               link_busy_in   = req_item.link_busy;
               link_error_in  = req_item.link_error;
               probe_valid_in = 1'b0;
               probe_port_in  = 16'd0;
               dup_in         = 1'b0;
               status_in      = STATUS_FILTERED;
               state_in       = S_REPORT;
               unique case (req_item.command)
                  CMD_START: begin
                     base_in     = first_port_ff;
                     size_in     = SIZE_W'(size_new);
                     cursor_in   = '0;
                     passes_in   = pass_limit_ff;
                     credit_in   = credit_limit_ff;
                     answered_in = '0;
                     abort_in    = 1'b0;
                     finished_in = (size_new == 17'd0);
                     send_en_in  = (size_new != 17'd0);
                     addr_in     = '0;
                     if (size_new != 17'd0) begin
                        state_in = S_CLEAR;
                     end
                  end
                  CMD_SEND: begin
                     if (send_en_ff && run) begin
                        state_in = S_WALK_RD;
                     end
                  end
                  CMD_RESPONSE: begin
                     if (run) begin
                        if (!in_range) begin
                           dup_in = 1'b1;
                        end else begin
                           addr_in  = idx_full[IDX_W-1:0];
                           state_in = S_RESP_RD;
                        end
                     end
                  end
                  CMD_TIMEOUT: begin
                     if (run) begin
                        if (passes_ff == 4'd0) begin
                           finished_in = 1'b1;
                           send_en_in  = 1'b0;
                        end else begin
                           credit_in  = credit_limit_ff;
                           send_en_in = 1'b1;
                        end
                     end
                  end
                  CMD_READ: begin
                     if (in_range) begin
                        addr_in  = idx_full[IDX_W-1:0];
                        state_in = S_READ_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_CLEAR: begin
            mem_we = 1'b1;
            if (clr_last) begin
               state_in = S_REPORT;
            end else begin
               addr_in = addr_ff + IDX_W'(1);
            end
         end

         S_WALK_RD: begin
            mem_raddr = cursor_ff;
            state_in  = S_WALK_CHK;
         end

         S_WALK_CHK: begin
            if (passes_ff == 4'd0) begin
               send_en_in = 1'b0;
               state_in   = S_REPORT;
            end else if (rd_data_ff != STATUS_FILTERED) begin
               cursor_in = step_cursor;
               passes_in = step_passes;
               state_in  = S_WALK_RD;
            end else begin
               state_in = S_REPORT;
               if (link_error_ff) begin
                  abort_in   = 1'b1;
                  send_en_in = 1'b0;
               end else if (link_busy_ff) begin
                  send_en_in = 1'b0;
               end else begin
                  probe_valid_in = 1'b1;
                  probe_port_in  = 16'(cursor_ff) + base_ff;
                  cursor_in      = step_cursor;
                  passes_in      = step_passes;
                  credit_in      = credit_dec;
                  if (credit_dec == 10'd0 || step_wrap) begin
                     send_en_in = 1'b0;
                  end
               end
            end
         end

         S_RESP_RD: begin
            state_in = S_RESP_CHK;
         end

         S_RESP_CHK: begin
            state_in = S_REPORT;
            if (rd_data_ff != STATUS_FILTERED) begin
               dup_in = 1'b1;
            end else begin
               mem_we      = 1'b1;
               mem_wdata   = kind_ff ? STATUS_CLOSED : STATUS_OPEN;
               answered_in = answered_inc;
               credit_in   = credit_inc;
               if (credit_inc == credit_limit_ff) begin
                  send_en_in = 1'b1;
               end
               if (answered_inc >= size_ff) begin
                  finished_in = 1'b1;
                  send_en_in  = 1'b0;
               end
            end
         end

         S_READ_RD: begin
            state_in = S_READ_CHK;
         end

         S_READ_CHK: begin
            status_in = rd_data_ff;
            state_in  = S_REPORT;
         end

         S_REPORT: begin
            if (!run) begin
               send_en_in = 1'b0;
            end
            rsp_valid_in               = 1'b1;
            rsp_item_in.probe_valid    = probe_valid_ff;
            rsp_item_in.probe_port     = probe_port_ff;
            rsp_item_in.restart_timer  = probe_valid_ff;
            rsp_item_in.send_enabled   = send_en_ff && run;
            rsp_item_in.running        = run;
            rsp_item_in.aborted        = abort_ff;
            rsp_item_in.duplicate      = dup_ff;
            rsp_item_in.entry_status   = status_ff;
            state_in                   = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         first_port_ff   <= FIRST_PORT_RESET;
         last_port_ff    <= LAST_PORT_RESET;
         credit_limit_ff <= CREDIT_LIMIT_RESET;
         pass_limit_ff   <= PASS_LIMIT_RESET;
         base_ff         <= 16'd0;
         size_ff         <= '0;
         cursor_ff       <= '0;
         passes_ff       <= 4'd0;
         credit_ff       <= 10'd0;
         answered_ff     <= '0;
         send_en_ff      <= 1'b0;
         abort_ff        <= 1'b0;
         finished_ff     <= 1'b1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         first_port_ff   <= first_port_in;
         last_port_ff    <= last_port_in;
         credit_limit_ff <= credit_limit_in;
         pass_limit_ff   <= pass_limit_in;
         base_ff         <= base_in;
         size_ff         <= size_in;
         cursor_ff       <= cursor_in;
         passes_ff       <= passes_in;
         credit_ff       <= credit_in;
         answered_ff     <= answered_in;
         send_en_ff      <= send_en_in;
         abort_ff        <= abort_in;
         finished_ff     <= finished_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      addr_ff        <= addr_in;
      kind_ff        <= kind_in;
      link_busy_ff   <= link_busy_in;
      link_error_ff  <= link_error_in;
      probe_valid_ff <= probe_valid_in;
      probe_port_ff  <= probe_port_in;
      dup_ff         <= dup_in;
      status_ff      <= status_in;
      rsp_item_ff    <= rsp_item_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

@@ design/psched_checker.sv @@
`default_nettype none

`include "probe_scheduler_with_credit_and_retry_top_macros.svh"

module psched_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     start,
   input wire logic                     busy,
   input wire logic                     rsp_valid,
   input wire psched_pkg::rsp_item_type rsp_item
);
   import psched_pkg::*;

   // Every accepted command makes the block busy in the cycle after it is taken.
   `PSCHED_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accept without busy")

   // A result closes its command, so the block is free while the result is shown.
   `PSCHED_ASSERT_SAME(a_rsp_then_free, clock, reset, rsp_valid, !busy, "busy during result")

   // A probe always restarts the response timer.
   `PSCHED_ASSERT_SAME(a_probe_timer, clock, reset, rsp_valid && rsp_item.probe_valid, rsp_item.restart_timer, "probe without timer restart")

   // Sending is only ever requested while the scan is running.
   `PSCHED_ASSERT_SAME(a_send_running, clock, reset, rsp_valid && rsp_item.send_enabled, rsp_item.running, "send enabled while stopped")

endmodule

bind probe_scheduler_with_credit_and_retry_top psched_checker u_psched_checker (.*);

`default_nettype wire
